// ===== src/ale_pkg.sv =====
package ale_pkg;

   // Widths of the item fields.
   localparam int CMD_W   = 3;
   localparam int DATA_W  = 32;
   localparam int POS_W   = 4;
   localparam int ROT_W   = 8;
   localparam int STAT_W  = 2;
   localparam int FIDX_W  = 3;
   localparam int LLEN_W  = 4;

   // Bit counter of the rotate remainder unit.
   localparam int ROT_CNT_W = $clog2(ROT_W);

   // Default list capacity.
   localparam int CAPACITY_DEF = 8;

   // Result status codes.
   localparam logic [STAT_W-1:0] STAT_OK    = STAT_W'(0);
   localparam logic [STAT_W-1:0] STAT_FULL  = STAT_W'(1);
   localparam logic [STAT_W-1:0] STAT_EMPTY = STAT_W'(2);
   localparam logic [STAT_W-1:0] STAT_RANGE = STAT_W'(3);

   typedef enum logic [CMD_W-1:0] {
      CMD_INS_FRONT = 3'd0,
      CMD_INS_END   = 3'd1,
      CMD_INS_AT    = 3'd2,
      CMD_DEL_FRONT = 3'd3,
      CMD_DEL_END   = 3'd4,
      CMD_DEL_AT    = 3'd5,
      CMD_SEARCH    = 3'd6,
      CMD_ROTATE    = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      OP_INS,
      OP_DEL,
      OP_SRCH,
      OP_ROT
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MOD,
      S_WALK,
      S_FINAL,
      S_RESP
   } state_type;

endpackage

// ===== src/ale_ram.sv =====
module ale_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/array_list_engine.sv =====
// Ordered list engine. The block keeps up to CAPACITY signed 32-bit entries
// in order, plus the current length, and takes one command per item: insert
// at the front, at the end or at a position, delete at the front, at the end
// or at a position (the removed value is returned), search for the first
// index that holds a key, or rotate the stored entries right by a count taken
// modulo the length. Every item gives exactly one result item carrying a
// status (ok, list full, list empty, position out of range), the search hit
// and its index, the removed value and the length after the command. Refused
// commands leave the list untouched. The entries live in one RAM with one
// write port and one registered read port, split into two banks of CAPACITY
// rounded up to a power of two words each; a rotate copies the list into the
// other bank and switches banks. The RAM needs no clearing pass, since only
// entries below the length are ever read. One item is handled at a time and
// the block is not ready while it works. The walk over the RAM moves one
// entry per cycle over the entries walked: the length minus the position
// for an insert or a delete, the whole list for a search or a rotate. A
// delete or a search gives its result when the walk ends; an insert then
// writes the new value into the gap, and a rotate works out a bit-serial
// remainder of the rotate count by the length before it walks. A refused
// command goes straight to its result. The result is held until it is
// taken, and the next item is accepted in the cycle after that.
module array_list_engine #(
   parameter int CAPACITY = ale_pkg::CAPACITY_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [ale_pkg::CMD_W-1:0]             req_command,
   input  logic signed [ale_pkg::DATA_W-1:0]     req_value,
   input  logic [ale_pkg::POS_W-1:0]             req_position,
   input  logic signed [ale_pkg::DATA_W-1:0]     req_search_key,
   input  logic [ale_pkg::ROT_W-1:0]             req_rotate_count,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [ale_pkg::STAT_W-1:0]            rsp_status,
   output logic                                  rsp_found,
   output logic [ale_pkg::FIDX_W-1:0]            rsp_found_index,
   output logic signed [ale_pkg::DATA_W-1:0]     rsp_removed_value,
   output logic [ale_pkg::LLEN_W-1:0]            rsp_list_length
);

   import ale_pkg::*;

   // Index of one entry, the length (which can reach CAPACITY), and the RAM
   // address: the bank bit on top of the entry index.
   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int LEN_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = IDX_W + 1;
   localparam int WW     = LEN_W + POS_W;

   // Control state.
   state_type            state_ff, state_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic                 bank_ff, bank_in;
   logic                 rd_vld_ff, rd_vld_in;

   // Item and walk registers.
   op_type               op_ff, op_in;
   logic [DATA_W-1:0]    value_ff, value_in;
   logic [DATA_W-1:0]    key_ff, key_in;
   logic [IDX_W-1:0]     pos_ff, pos_in;
   logic [IDX_W-1:0]     rd_idx_ff, rd_idx_in;
   logic [LEN_W-1:0]     rd_left_ff, rd_left_in;
   logic                 rd_dn_ff, rd_dn_in;
   logic [IDX_W-1:0]     wr_idx_ff, wr_idx_in;
   logic                 skip_ff, skip_in;
   logic [LEN_W-1:0]     rem_ff, rem_in;
   logic [ROT_W-1:0]     rot_ff, rot_in;
   logic [ROT_CNT_W-1:0] cnt_ff, cnt_in;

   // Result registers.
   logic [STAT_W-1:0]    status_ff, status_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     fidx_ff, fidx_in;
   logic [DATA_W-1:0]    removed_ff, removed_in;

   // Decode of the incoming item against the current length.
   logic [STAT_W-1:0]    dec_status;
   op_type               dec_op;
   logic [IDX_W-1:0]     dec_p;
   logic [IDX_W-1:0]     dec_rd_idx;
   logic [LEN_W-1:0]     dec_left;
   logic                 dec_dn;
   logic [IDX_W-1:0]     dec_wr;

   // Sequencer outputs.
   logic                 accept;
   logic                 issue;
   logic                 arrive;
   logic                 walk_done;
   logic                 mod_last;

   // RAM port.
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [DATA_W-1:0]    wr_data;
   logic [ADDR_W-1:0]    rd_addr;
   logic [DATA_W-1:0]    rd_data;

   // Shared helpers.
   logic [LEN_W-1:0]     len_m1;
   logic [LEN_W:0]       rem_sh;
   logic [LEN_W:0]       rem_diff;
   logic [LEN_W-1:0]     rem_next;
   logic [IDX_W+FIDX_W-1:0] fidx_wide;
   logic [LEN_W+LLEN_W-1:0] len_wide;

   assign len_m1   = len_ff - LEN_W'(1);
   assign rem_sh   = {rem_ff, rot_ff[ROT_W-1]};
   assign rem_diff = rem_sh - {1'b0, len_ff};
   assign rem_next = (rem_sh >= {1'b0, len_ff}) ? rem_diff[LEN_W-1:0] : rem_sh[LEN_W-1:0];

   // Work out the status and the walk that the command needs.
   always_comb begin
      logic [WW-1:0] len_w;
      logic [WW-1:0] pos_w;
      logic [WW-1:0] p_w;
      logic          full;
      logic          empty;
      len_w      = {{POS_W{1'b0}}, len_ff};
      pos_w      = {{LEN_W{1'b0}}, req_position};
      full       = (len_ff == LEN_W'(CAPACITY));
      empty      = (len_ff == '0);
      p_w        = '0;
      dec_status = STAT_OK;
      dec_op     = OP_SRCH;
      dec_rd_idx = '0;
      dec_left   = len_ff;
      dec_dn     = 1'b0;
      dec_wr     = '0;
      unique case (cmd_type'(req_command)) inside
         CMD_INS_FRONT, CMD_INS_END, CMD_INS_AT: begin
            dec_op = OP_INS;
            if (cmd_type'(req_command) == CMD_INS_FRONT) begin
               p_w = '0;
            end else if (cmd_type'(req_command) == CMD_INS_END) begin
               p_w = len_w;
            end else begin
               p_w = pos_w;
            end
            if (full) begin
               dec_status = STAT_FULL;
            end else if (p_w > len_w) begin
               dec_status = STAT_RANGE;
            end
            // Entries from the top down to the position move up by one.
            dec_rd_idx = len_m1[IDX_W-1:0];
            dec_left   = len_ff - p_w[LEN_W-1:0];
            dec_dn     = 1'b1;
            dec_wr     = len_ff[IDX_W-1:0];
         end
         CMD_DEL_FRONT, CMD_DEL_END, CMD_DEL_AT: begin
            dec_op = OP_DEL;
            if (cmd_type'(req_command) == CMD_DEL_FRONT) begin
               p_w = '0;
            end else if (cmd_type'(req_command) == CMD_DEL_END) begin
               p_w = len_w - WW'(1);
            end else begin
               p_w = pos_w;
            end
            if (empty) begin
               dec_status = STAT_EMPTY;
            end else if (p_w >= len_w) begin
               dec_status = STAT_RANGE;
            end
            // The entry at the position is read out first, the ones above it
            // move down by one.
            dec_rd_idx = p_w[IDX_W-1:0];
            dec_left   = len_ff - p_w[LEN_W-1:0];
            dec_wr     = p_w[IDX_W-1:0];
         end
         CMD_SEARCH: begin
            dec_op = OP_SRCH;
         end
         CMD_ROTATE: begin
            dec_op = OP_ROT;
            if (empty) begin
               dec_status = STAT_EMPTY;
            end
         end
         default: begin
            dec_op = OP_SRCH;
         end
      endcase
      dec_p = p_w[IDX_W-1:0];
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (dec_status != STAT_OK) begin
                  state_in = S_RESP;
               end else if (dec_op == OP_ROT) begin
                  state_in = S_MOD;
               end else begin
                  state_in = S_WALK;
               end
            end
         end
         S_MOD: begin
            if (mod_last) begin
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (walk_done) begin
               state_in = (op_ff == OP_INS) ? S_FINAL : S_RESP;
            end
         end
         S_FINAL: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      issue     = 1'b0;
      arrive    = 1'b0;
      walk_done = 1'b0;
      mod_last  = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
         end
         S_MOD: begin
            mod_last = (cnt_ff == ROT_CNT_W'(ROT_W - 1));
         end
         S_WALK: begin
            issue     = (rd_left_ff != '0);
            arrive    = rd_vld_ff;
            walk_done = (rd_left_ff == '0);
         end
         S_FINAL: begin
         end
         S_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign accept  = req_valid && req_ready;
   assign rd_addr = {bank_ff, rd_idx_ff};

   // Datapath: one read and at most one write of the entry RAM per cycle.
   always_comb begin
      len_in     = len_ff;
      bank_in    = bank_ff;
      rd_vld_in  = issue;
      op_in      = op_ff;
      value_in   = value_ff;
      key_in     = key_ff;
      pos_in     = pos_ff;
      rd_idx_in  = rd_idx_ff;
      rd_left_in = rd_left_ff;
      rd_dn_in   = rd_dn_ff;
      wr_idx_in  = wr_idx_ff;
      skip_in    = skip_ff;
      rem_in     = rem_ff;
      rot_in     = rot_ff;
      cnt_in     = cnt_ff;
      status_in  = status_ff;
      found_in   = found_ff;
      fidx_in    = fidx_ff;
      removed_in = removed_ff;
      wr_en      = 1'b0;
      wr_addr    = {bank_ff, wr_idx_ff};
      wr_data    = rd_data;

      if (accept) begin
         op_in      = dec_op;
         value_in   = req_value;
         key_in     = req_search_key;
         pos_in     = dec_p;
         rd_idx_in  = dec_rd_idx;
         rd_left_in = dec_left;
         rd_dn_in   = dec_dn;
         wr_idx_in  = dec_wr;
         skip_in    = 1'b1;
         rem_in     = '0;
         rot_in     = req_rotate_count;
         cnt_in     = '0;
         status_in  = dec_status;
         found_in   = 1'b0;
         fidx_in    = '0;
         removed_in = '0;
      end

      // Remainder of the rotate count by the length, one bit per cycle.
      if (state_ff == S_MOD) begin
         rem_in = rem_next;
         rot_in = {rot_ff[ROT_W-2:0], 1'b0};
         cnt_in = cnt_ff + ROT_CNT_W'(1);
         if (mod_last) begin
            wr_idx_in = rem_next[IDX_W-1:0];
         end
      end

      if (issue) begin
         rd_idx_in  = rd_dn_ff ? (rd_idx_ff - IDX_W'(1)) : (rd_idx_ff + IDX_W'(1));
         rd_left_in = rd_left_ff - LEN_W'(1);
      end

      // Data read in the previous cycle arrives here.
      if (arrive) begin
         case (op_ff)
            OP_INS: begin
               wr_en     = 1'b1;
               wr_idx_in = wr_idx_ff - IDX_W'(1);
            end
            OP_DEL: begin
               if (skip_ff) begin
                  removed_in = rd_data;
                  skip_in    = 1'b0;
               end else begin
                  wr_en     = 1'b1;
                  wr_idx_in = wr_idx_ff + IDX_W'(1);
               end
            end
            OP_SRCH: begin
               if (!found_ff && (rd_data == key_ff)) begin
                  found_in = 1'b1;
                  fidx_in  = wr_idx_ff;
               end
               wr_idx_in = wr_idx_ff + IDX_W'(1);
            end
            default: begin
               // Rotate copies into the other bank, wrapping at the length.
               wr_en     = 1'b1;
               wr_addr   = {~bank_ff, wr_idx_ff};
               wr_idx_in = (wr_idx_ff == len_m1[IDX_W-1:0]) ? '0 : (wr_idx_ff + IDX_W'(1));
            end
         endcase
      end

      if (walk_done) begin
         if (op_ff == OP_DEL) begin
            len_in = len_ff - LEN_W'(1);
         end else if (op_ff == OP_ROT) begin
            bank_in = ~bank_ff;
         end
      end

      // The new value goes into the gap that the walk opened.
      if (state_ff == S_FINAL) begin
         wr_en   = 1'b1;
         wr_addr = {bank_ff, pos_ff};
         wr_data = value_ff;
         len_in  = len_ff + LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         len_ff    <= '0;
         bank_ff   <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         len_ff    <= len_in;
         bank_ff   <= bank_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      value_ff   <= value_in;
      key_ff     <= key_in;
      pos_ff     <= pos_in;
      rd_idx_ff  <= rd_idx_in;
      rd_left_ff <= rd_left_in;
      rd_dn_ff   <= rd_dn_in;
      wr_idx_ff  <= wr_idx_in;
      skip_ff    <= skip_in;
      rem_ff     <= rem_in;
      rot_ff     <= rot_in;
      cnt_ff     <= cnt_in;
      status_ff  <= status_in;
      found_ff   <= found_in;
      fidx_ff    <= fidx_in;
      removed_ff <= removed_in;
   end

   // Each bank spans the full entry index range, so every bank and index pair
   // is a valid address even when CAPACITY is not a power of two.
   ale_ram #(
      .WIDTH (DATA_W),
      .DEPTH (2 ** ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The result fields are masked to their port widths.
   assign fidx_wide         = {{FIDX_W{1'b0}}, fidx_ff};
   assign len_wide          = {{LLEN_W{1'b0}}, len_ff};
   assign rsp_status        = status_ff;
   assign rsp_found         = found_ff;
   assign rsp_found_index   = fidx_wide[FIDX_W-1:0];
   assign rsp_removed_value = removed_ff;
   assign rsp_list_length   = len_wide[LLEN_W-1:0];

`ifndef SYNTHESIS
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_W'(CAPACITY))
      else $error("list length above capacity");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK) |-> (rd_left_ff <= len_ff))
      else $error("walk count exceeds list length");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> ((state_ff == S_WALK) || (state_ff == S_FINAL)))
      else $error("entry write outside a walk");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_status == STAT_OK))
      else $error("search hit reported with a failing status");
`endif

endmodule

// ===== test/array_list_engine_tb.sv =====
module array_list_engine_tb;

   import ale_pkg::*;

   // The list holds at most this many entries. The engine is built with the same value.
   localparam int LIST_CAPACITY = CAPACITY_DEF;

   // Half of the clock period in time units.
   localparam int HALF_PERIOD = 6;

   // The longest correct item is a rotate of a full list.
   // The drain after the last result waits longer than that item takes.
   localparam int DRAIN_CYCLES = 40;

   // Run-away guard. A correct run with the worst gaps and stalls ends before this limit.
   localparam int CYCLE_LIMIT = 400000;

   // One result item of the engine, at the widths of its ports.
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic              found;
      logic [FIDX_W-1:0] found_index;
      logic [DATA_W-1:0] removed_value;
      logic [LLEN_W-1:0] list_length;
   } list_reply_type;

   logic                     clock;
   logic                     reset            = 1'b1;
   logic                     req_valid        = 1'b0;
   logic                     req_ready;
   logic [CMD_W-1:0]         req_command      = '0;
   logic signed [DATA_W-1:0] req_value        = '0;
   logic [POS_W-1:0]         req_position     = '0;
   logic signed [DATA_W-1:0] req_search_key   = '0;
   logic [ROT_W-1:0]         req_rotate_count = '0;
   logic                     rsp_valid;
   logic                     rsp_ready        = 1'b0;
   logic [STAT_W-1:0]        rsp_status;
   logic                     rsp_found;
   logic [FIDX_W-1:0]        rsp_found_index;
   logic signed [DATA_W-1:0] rsp_removed_value;
   logic [LLEN_W-1:0]        rsp_list_length;

   // Shadow copy of the list. It is updated at the edge where each item is accepted.
   // Entries at and above shadow_length are never read.
   logic [DATA_W-1:0] shadow_entries [LIST_CAPACITY];
   int                shadow_length = 0;

   // Replies that the engine still owes, oldest first.
   list_reply_type expected_replies [$];
   list_reply_type oldest_reply;

   // Counters for the run summary and the final verdict.
   int fail_count    = 0;
   int items_sent    = 0;
   int replies_seen  = 0;
   int refused_count = 0;
   int hit_count     = 0;
   int peak_length   = 0;
   int cmd_seen [8]  = '{default: 0};
   longint cycle_count = 0;

   // State of the sender's burst pattern.
   int burst_left = 0;

   // State of the receiver's stall pattern. It is reloaded when pattern_phase wraps to zero.
   logic [15:0] ready_pattern = '0;
   int          pattern_phase = 0;

   array_list_engine #(
      .CAPACITY(LIST_CAPACITY)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_value        (req_value),
      .req_position     (req_position),
      .req_search_key   (req_search_key),
      .req_rotate_count (req_rotate_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_found        (rsp_found),
      .rsp_found_index  (rsp_found_index),
      .rsp_removed_value(rsp_removed_value),
      .rsp_list_length  (rsp_list_length)
   );

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   // Applies one command to the shadow list and returns the reply it should produce.
   // A refused command leaves the list alone. Fields that the command does not define
   // stay zero.
   function automatic list_reply_type apply_list_command(input cmd_type cmd,
         input logic [DATA_W-1:0] val, input logic [POS_W-1:0] pos,
         input logic [DATA_W-1:0] key, input logic [ROT_W-1:0] rot);
      list_reply_type reply;
      int          slot;
      int          shift;
      int          i;
      logic [DATA_W-1:0] spun [LIST_CAPACITY];
      reply = '0;
      case (cmd)
         CMD_INS_FRONT, CMD_INS_END, CMD_INS_AT: begin
            slot = (cmd == CMD_INS_FRONT) ? 0 :
                   (cmd == CMD_INS_END)   ? shadow_length : int'(pos);
            // A full list refuses before the position is looked at.
            if (shadow_length >= LIST_CAPACITY) begin
               reply.status = STAT_FULL;
            end else if (slot > shadow_length) begin
               reply.status = STAT_RANGE;
            end else begin
               for (i = shadow_length; i > slot; i--)
                  shadow_entries[i] = shadow_entries[i - 1];
               shadow_entries[slot] = val;
               shadow_length++;
            end
         end
         CMD_DEL_FRONT, CMD_DEL_END, CMD_DEL_AT: begin
            slot = (cmd == CMD_DEL_FRONT) ? 0 :
                   (cmd == CMD_DEL_END)   ? shadow_length - 1 : int'(pos);
            if (shadow_length == 0) begin
               reply.status = STAT_EMPTY;
            end else if (slot >= shadow_length) begin
               reply.status = STAT_RANGE;
            end else begin
               reply.removed_value = shadow_entries[slot];
               for (i = slot; i < shadow_length - 1; i++)
                  shadow_entries[i] = shadow_entries[i + 1];
               shadow_length--;
            end
         end
         CMD_SEARCH: begin
            // Scanning downward leaves the lowest matching index in place.
            for (i = shadow_length - 1; i >= 0; i--) begin
               if (shadow_entries[i] == key) begin
                  reply.found       = 1'b1;
                  reply.found_index = FIDX_W'(i);
               end
            end
         end
         default: begin
            if (shadow_length == 0) begin
               reply.status = STAT_EMPTY;
            end else begin
               shift = int'(rot) % shadow_length;
               for (i = 0; i < shadow_length; i++)
                  spun[(i + shift) % shadow_length] = shadow_entries[i];
               for (i = 0; i < shadow_length; i++)
                  shadow_entries[i] = spun[i];
            end
         end
      endcase
      reply.list_length = LLEN_W'(shadow_length);
      return reply;
   endfunction

   // Sends one item. The sender works in bursts. Before a new burst it may drop valid
   // for a random gap. Inside a burst valid stays high from item to item. The reply
   // is predicted at the edge that accepts the item.
   task automatic send_command(input cmd_type cmd, input logic [DATA_W-1:0] val,
         input logic [POS_W-1:0] pos, input logic [DATA_W-1:0] key,
         input logic [ROT_W-1:0] rot);
      int             gap;
      list_reply_type reply;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         case ($urandom_range(0, 3))
            0:       gap = 0;
            1, 2:    gap = $urandom_range(1, 4);
            default: gap = $urandom_range(5, 20);
         endcase
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_value        <= val;
      req_position     <= pos;
      req_search_key   <= key;
      req_rotate_count <= rot;
      do @(posedge clock); while (!req_ready);
      reply = apply_list_command(cmd, val, pos, key, rot);
      expected_replies.push_back(reply);
      items_sent++;
      cmd_seen[cmd]++;
      if (reply.status != STAT_OK) refused_count++;
      if (reply.found) hit_count++;
      if (shadow_length > peak_length) peak_length = shadow_length;
   endtask

   // Commands on an empty list. Each delete and the rotate are refused as empty, and a
   // search misses.
   task automatic test_empty_list();
      send_command(CMD_DEL_FRONT, '0, 4'd0, '0, 8'd0);
      send_command(CMD_DEL_END,   '0, 4'd0, '0, 8'd0);
      send_command(CMD_DEL_AT,    '0, 4'd0, '0, 8'd0);
      send_command(CMD_ROTATE,    '0, 4'd0, '0, 8'd5);
      send_command(CMD_SEARCH,    '0, 4'd0, '0, 8'd0);
   endtask

   // Grows the list to capacity through every insert path, using the extreme values.
   // Then it checks that a full list refuses inserts, even one whose position is also
   // out of range.
   task automatic test_fill_to_capacity();
      send_command(CMD_INS_AT,    32'h7FFF_FFFF, 4'd0, '0, 8'd0);
      send_command(CMD_INS_FRONT, 32'h8000_0000, 4'd0, '0, 8'd0);
      send_command(CMD_INS_END,   32'hFFFF_FFFF, 4'd0, '0, 8'd0);
      send_command(CMD_INS_AT,    32'h0000_0000, 4'd1, '0, 8'd0);
      send_command(CMD_INS_END,   32'd5,         4'd0, '0, 8'd0);
      send_command(CMD_INS_FRONT, 32'd5,         4'd0, '0, 8'd0);
      send_command(CMD_INS_AT,    32'h55AA_55AA, 4'd6, '0, 8'd0);
      send_command(CMD_INS_END,   32'hA55A_A55A, 4'd0, '0, 8'd0);
      send_command(CMD_INS_END,   32'd1,         4'd0, '0, 8'd0);
      send_command(CMD_INS_AT,    32'd2,         4'd15, '0, 8'd0);
   endtask

   // The key 5 sits in the list twice, so the search must return the lower index.
   // The rotates use the largest count and a multiple of the length.
   task automatic test_search_and_rotate();
      send_command(CMD_SEARCH, '0, 4'd0, 32'd5,         8'd0);
      send_command(CMD_SEARCH, '0, 4'd0, 32'h1234_5678, 8'd0);
      send_command(CMD_ROTATE, '0, 4'd0, '0,            8'd255);
      send_command(CMD_ROTATE, '0, 4'd0, '0,            8'(LIST_CAPACITY));
   endtask

   // Deletes through each path, including the last slot and a position one past the
   // end. The last item is an insert whose position lies beyond the length.
   task automatic test_delete_edges();
      send_command(CMD_DEL_AT,    '0, 4'd8, '0, 8'd0);
      send_command(CMD_DEL_AT,    '0, 4'd7, '0, 8'd0);
      send_command(CMD_DEL_AT,    '0, 4'd3, '0, 8'd0);
      send_command(CMD_DEL_FRONT, '0, 4'd0, '0, 8'd0);
      send_command(CMD_DEL_END,   '0, 4'd0, '0, 8'd0);
      send_command(CMD_INS_AT,    32'd9, 4'd5, '0, 8'd0);
   endtask

   // Mixed traffic. The balance of inserts against deletes changes every 40 items, so
   // the length sweeps between empty and full. Values often come from a small pool,
   // and search keys are usually taken from the list, so duplicates and hits are
   // common. Most positions lie near the valid range. A few take any value the
   // 4-bit field allows.
   task automatic test_random_traffic(input int n_items);
      cmd_type           cmd;
      logic [DATA_W-1:0] val;
      logic [DATA_W-1:0] key;
      logic [POS_W-1:0]  pos;
      int                pick;
      int                grow_bias;
      int                n;
      grow_bias = 50;
      for (n = 0; n < n_items; n++) begin
         if (n % 40 == 0) grow_bias = $urandom_range(15, 85);
         pick = $urandom_range(0, 99);
         if (pick < 15)
            cmd = CMD_SEARCH;
         else if (pick < 27)
            cmd = CMD_ROTATE;
         else if (pick - 27 < grow_bias * 73 / 100)
            cmd = cmd_type'($urandom_range(0, 2));
         else
            cmd = cmd_type'($urandom_range(3, 5));

         if ($urandom_range(0, 3) == 0)
            val = DATA_W'($urandom_range(0, 7)) - DATA_W'(4);
         else
            val = $urandom;

         if (shadow_length > 0 && $urandom_range(0, 9) < 6)
            key = shadow_entries[$urandom_range(0, shadow_length - 1)];
         else if ($urandom_range(0, 1) == 0)
            key = DATA_W'($urandom_range(0, 7)) - DATA_W'(4);
         else
            key = $urandom;

         if ($urandom_range(0, 9) == 0)
            pos = POS_W'($urandom_range(0, 15));
         else
            pos = POS_W'($urandom_range(0, shadow_length));

         send_command(cmd, val, pos, key, ROT_W'($urandom_range(0, 255)));
      end
   endtask

   // The receiver stalls on its own 16-bit pattern. The pattern is either always
   // ready, random, mostly stalled, or one block of ready cycles at a random offset.
   always @(posedge clock) begin
      if (pattern_phase == 0) begin
         case ($urandom_range(0, 3))
            0:       ready_pattern = 16'hFFFF;
            1:       ready_pattern = 16'($urandom);
            2:       ready_pattern = 16'($urandom) & 16'($urandom);
            default: ready_pattern = 16'h00FF << $urandom_range(0, 8);
         endcase
      end
      rsp_ready     <= ready_pattern[pattern_phase];
      pattern_phase = (pattern_phase + 1) % 16;
   end

   // Every result that is taken is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         replies_seen++;
         if (expected_replies.size() == 0) begin
            $error("unexpected result: no item is waiting for one");
            fail_count++;
         end else begin
            oldest_reply = expected_replies.pop_front();
            if (rsp_status !== oldest_reply.status) begin
               $error("status: expected %0d, got %0d", oldest_reply.status, rsp_status);
               fail_count++;
            end
            if (rsp_found !== oldest_reply.found) begin
               $error("found: expected %0d, got %0d", oldest_reply.found, rsp_found);
               fail_count++;
            end
            if (rsp_found_index !== oldest_reply.found_index) begin
               $error("found_index: expected %0d, got %0d",
                      oldest_reply.found_index, rsp_found_index);
               fail_count++;
            end
            if (rsp_removed_value !== oldest_reply.removed_value) begin
               $error("removed_value: expected %0d, got %0d",
                      $signed(oldest_reply.removed_value), rsp_removed_value);
               fail_count++;
            end
            if (rsp_list_length !== oldest_reply.list_length) begin
               $error("list_length: expected %0d, got %0d",
                      oldest_reply.list_length, rsp_list_length);
               fail_count++;
            end
         end
      end
   end

   // This guard ends a run that hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results still owed.",
                  cycle_count, expected_replies.size());
         $display("** array_list_engine: FAILED **");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_list();
      test_fill_to_capacity();
      test_search_and_rotate();
      test_delete_edges();
      test_random_traffic(525);

      // The last item has been accepted. Valid drops here and stays low.
      req_valid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d items: %0d inserts, %0d deletes, %0d searches, %0d rotates.",
               items_sent, cmd_seen[CMD_INS_FRONT] + cmd_seen[CMD_INS_END] +
               cmd_seen[CMD_INS_AT], cmd_seen[CMD_DEL_FRONT] + cmd_seen[CMD_DEL_END] +
               cmd_seen[CMD_DEL_AT], cmd_seen[CMD_SEARCH], cmd_seen[CMD_ROTATE]);
      $display("Checked %0d results: %0d refused, %0d search hits, peak length %0d.",
               replies_seen, refused_count, hit_count, peak_length);
      if (fail_count == 0) begin
         $display("** array_list_engine: PASSED **");
      end else begin
         $display("** array_list_engine: FAILED **");
      end
      $finish;
   end

endmodule

// ===== array_list_engine.f =====
src/ale_pkg.sv
src/ale_ram.sv
src/array_list_engine.sv
test/array_list_engine_tb.sv
